// File: sv/sequence_ring_buffer_query_defines.svh
`ifndef SEQUENCE_RING_BUFFER_QUERY_DEFINES_SVH
`define SEQUENCE_RING_BUFFER_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SRBQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SRBQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/srbq_pkg.sv
`default_nettype none

package srbq_pkg;

	localparam int DEPTH_DEF        = 32;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int SEQ_W            = 32;
	localparam int PAY_W            = 32;
	localparam int CFG_W            = 6;

	localparam logic [1:0] FUNC_PUT   = 2'd0;
	localparam logic [1:0] FUNC_FETCH = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [SEQ_W-1:0] seq_value;
		logic [PAY_W-1:0]        payload;
	} req_t;

	typedef struct packed {
		logic signed [SEQ_W-1:0] out_seq;
		logic [PAY_W-1:0]        out_payload;
		logic                    item_valid;
		logic                    too_high;
		logic                    available;
		logic                    last;
	} rsp_t;

	typedef logic [CFG_W-1:0] cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// File: sv/srbq_chan_if.sv
`default_nettype none

interface srbq_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/sequence_ring_buffer_query.sv
// Put: no result; the next item is taken the following cycle.
// Fetch/query: the ring is read one entry per cycle through the single RAM read port, except
//   while a fetch beat waits at the output; a fetch sends each match as a record beat when
//   the next is found. After up to DEPTH entries, or at once for a too-high fetch, ST_FIN
//   registers the final beat when the output is free, and ST_IDLE then takes the next item.
// Reset (arst_n low, asynchronous): ring empty, capacity DEPTH, highest sequence 0; RAM kept.
`default_nettype none
`include "sequence_ring_buffer_query_defines.svh"

module sequence_ring_buffer_query #(
	parameter int DEPTH        = srbq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = srbq_pkg::PAYLOAD_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	srbq_chan_if.sink   req,
	srbq_chan_if.source rsp,
	srbq_chan_if.sink   cfg
);

	localparam int SW = srbq_pkg::SEQ_W;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (PAYLOAD_BITS < srbq_pkg::PAY_W) ? PAYLOAD_BITS : srbq_pkg::PAY_W;
	localparam int MW = SW + KW;

	srbq_pkg::state_t state_q, state_d;

	logic [PW-1:0]        wp_q, rp_q, idx_q;
	logic                 full_q;
	logic signed [SW-1:0] hi_q;
	logic [CW-1:0]        cap_q, left_q;
	logic                 rd_v_s1;
	logic                 pend_v_q, found_q, th_q;
	logic                 out_v_q;

	logic signed [SW-1:0] seq_q, pend_seq_q;
	logic [KW-1:0]        pend_pay_q;
	logic                 fetch_q;
	srbq_pkg::rsp_t       out_q, out_d;

	logic                 ram_we, ram_re;
	logic [MW-1:0]        ram_rdata;
	logic signed [SW-1:0] rd_seq;
	logic [KW-1:0]        rd_pay;

	logic                 out_free, out_load, match, push, stall;
	logic                 put_fire, scan_fire, th_fire;
	logic [CW-1:0]        fill;
	logic [PW-1:0]        wp_n, rp_n;
	logic signed [SW:0]   seq_x, hi_x1;
	logic [CW-1:0]        cap_d;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p, input logic [CW-1:0] c);
		logic [CW-1:0] n;
		n = CW'(p) + CW'(1);
		bump = (n == c) ? '0 : PW'(n);
	endfunction

	// Single write (puts, idle only) and single read (scan only): no port overlap.
	srbq_ram #(
		.WIDTH(MW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata({req.data.seq_value, req.data.payload[KW-1:0]}),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign rd_seq = ram_rdata[MW-1 -: SW];
	assign rd_pay = ram_rdata[KW-1:0];

	assign out_free = !out_v_q || rsp.ready;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;
	assign cfg.ready = 1'b1;

	assign fill = full_q ? cap_q :
		(wp_q >= rp_q) ? CW'(wp_q - rp_q) : cap_q + CW'(wp_q) - CW'(rp_q);

	assign seq_x = {req.data.seq_value[SW-1], req.data.seq_value};
	assign hi_x1 = {hi_q[SW-1], hi_q} + (SW+1)'(1);

	assign rp_n = full_q ? bump(rp_q, cap_q) : rp_q;
	assign wp_n = bump(wp_q, cap_q);

	assign cap_d = (cfg.data == '0) ? CW'(1) :
		(int'(cfg.data) > DEPTH) ? CW'(DEPTH) : CW'(cfg.data);

	assign match = rd_v_s1 && (rd_seq >= seq_q);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		push      = 1'b0;
		stall     = 1'b0;
		out_load  = 1'b0;
		put_fire  = 1'b0;
		scan_fire = 1'b0;
		th_fire   = 1'b0;
		out_d     = '0;
		case (state_q)
			srbq_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (req.data.func)
						srbq_pkg::FUNC_PUT: begin
							put_fire = 1'b1;
							ram_we   = 1'b1;
						end
						srbq_pkg::FUNC_FETCH: begin
							if (seq_x > hi_x1) begin
								th_fire = 1'b1;
								state_d = srbq_pkg::ST_FIN;
							end else begin
								scan_fire = 1'b1;
								state_d   = srbq_pkg::ST_SCAN;
							end
						end
						srbq_pkg::FUNC_QUERY: begin
							scan_fire = 1'b1;
							state_d   = srbq_pkg::ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			srbq_pkg::ST_SCAN: begin
				push   = match && fetch_q && pend_v_q;
				stall  = push && !out_free;
				ram_re = (left_q != '0) && !stall;
				if (push && out_free) begin
					out_load          = 1'b1;
					out_d.out_seq     = pend_seq_q;
					out_d.out_payload = srbq_pkg::PAY_W'(pend_pay_q);
					out_d.item_valid  = 1'b1;
				end
				if (left_q == '0 && !rd_v_s1) begin
					state_d = srbq_pkg::ST_FIN;
				end
			end
			srbq_pkg::ST_FIN: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_d.last = 1'b1;
					if (!fetch_q) begin
						out_d.available = found_q;
					end else if (th_q) begin
						out_d.too_high = 1'b1;
					end else if (pend_v_q) begin
						out_d.out_seq     = pend_seq_q;
						out_d.out_payload = srbq_pkg::PAY_W'(pend_pay_q);
						out_d.item_valid  = 1'b1;
					end
					state_d = srbq_pkg::ST_IDLE;
				end
			end
			default: state_d = srbq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srbq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			full_q   <= 1'b0;
			hi_q     <= '0;
			cap_q    <= CW'(DEPTH);
			left_q   <= '0;
			idx_q    <= '0;
			rd_v_s1  <= 1'b0;
			pend_v_q <= 1'b0;
			found_q  <= 1'b0;
			th_q     <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (cfg.valid) begin
				cap_q  <= cap_d;
				wp_q   <= '0;
				rp_q   <= '0;
				full_q <= 1'b0;
			end else if (put_fire) begin
				rp_q   <= rp_n;
				wp_q   <= wp_n;
				full_q <= (wp_n == rp_n);
				if (req.data.seq_value > hi_q) begin
					hi_q <= req.data.seq_value;
				end
			end
			if (th_fire) begin
				th_q     <= 1'b1;
				pend_v_q <= 1'b0;
			end
			if (scan_fire) begin
				th_q     <= 1'b0;
				pend_v_q <= 1'b0;
				found_q  <= 1'b0;
				rd_v_s1  <= 1'b0;
				idx_q    <= rp_q;
				left_q   <= (req.data.func == srbq_pkg::FUNC_FETCH ||
					req.data.seq_value <= hi_q) ? fill : '0;
			end
			if (state_q == srbq_pkg::ST_SCAN && !stall) begin
				rd_v_s1 <= ram_re;
				if (ram_re) begin
					idx_q  <= bump(idx_q, cap_q);
					left_q <= left_q - CW'(1);
				end
				if (match) begin
					if (fetch_q) begin
						pend_v_q <= 1'b1;
					end else begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (th_fire || scan_fire) begin
			seq_q   <= req.data.seq_value;
			fetch_q <= (req.data.func == srbq_pkg::FUNC_FETCH);
		end
		if (state_q == srbq_pkg::ST_SCAN && !stall && match && fetch_q) begin
			pend_seq_q <= rd_seq;
			pend_pay_q <= rd_pay;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	`SRBQ_ASSERT_NOW(a_full_ptrs, full_q, wp_q == rp_q, "full ring with unequal pointers")
	`SRBQ_ASSERT_NOW(a_ptr_range, 1'b1, CW'(wp_q) < cap_q && CW'(rp_q) < cap_q,
		"ring pointer at or beyond capacity")
	`SRBQ_ASSERT_NOW(a_left_range, state_q == srbq_pkg::ST_SCAN, left_q <= cap_q,
		"scan count exceeds capacity")
	`SRBQ_ASSERT_NOW(a_stall_noread, stall, !ram_re, "RAM read issued during output stall")
	`SRBQ_ASSERT_NEXT(a_fin_result, state_q == srbq_pkg::ST_FIN && out_free, out_v_q,
		"final result not presented")

endmodule

`default_nettype wire

// File: sv/srbq_ram.sv
`default_nettype none

module srbq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
